// ----- src/ipr_pkg.sv -----
// Shared types, constants and helpers for the id pool with reuse delay.
// No dependencies; imported by every module of the block.
package ipr_pkg;

  // Pool size and derived widths
  localparam int NUM_IDS  = 1024;
  localparam int ID_W     = $clog2(NUM_IDS);
  localparam int LINK_W   = $clog2(NUM_IDS) + 1;
  localparam int CNT_W    = $clog2(NUM_IDS + 1);
  localparam int OUT_CNT_W = 11;
  localparam int REQ_ID_W  = 11;
  localparam int TIME_W    = 32;
  localparam int HOLD_RESET = 5000;

  localparam logic [LINK_W-1:0] LINK_NULL = LINK_W'(NUM_IDS);

  // Request codes
  typedef enum logic [1:0] {
    REQ_ALLOC   = 2'd0,
    REQ_FREE    = 2'd1,
    REQ_RELEASE = 2'd2,
    REQ_CLEAR   = 2'd3
  } req_t;

  // Result status codes
  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_EMPTY   = 2'd1,
    STAT_BAD     = 2'd2,
    STAT_IGNORED = 2'd3
  } status_t;

  // Per-entry state
  typedef enum logic [1:0] {
    ES_FREE  = 2'd0,
    ES_ALLOC = 2'd1,
    ES_HELD  = 2'd2
  } entry_state_t;

  // Register indexes on the config port
  localparam int REG_HOLD_TICKS = 0;

  // Access to the entry store for one cycle
  typedef struct packed {
    logic [ID_W-1:0]   rd_addr;
    logic [ID_W-1:0]   wr_addr;
    logic              link_we;
    logic [LINK_W-1:0] link_wd;
    logic              state_we;
    entry_state_t      state_wd;
    logic              exp_we;
    logic [TIME_W-1:0] exp_wd;
  } store_req_t;

  // Registered read data from the entry store
  typedef struct packed {
    logic [LINK_W-1:0] link;
    entry_state_t      state;
    logic [TIME_W-1:0] expiry;
  } store_rsp_t;

  // True when a link points past the last entry
  function automatic logic is_null(input logic [LINK_W-1:0] l);
    is_null = (l >= LINK_NULL);
  endfunction

endpackage

// ----- src/ipr_cfg.sv -----
// APB-style register port holding hold_ticks.
// Depends on ipr_pkg.
module ipr_cfg import ipr_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [1:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output logic [TIME_W-1:0] hold_ticks
);

  logic hit;

  // Only the word at offset zero decodes
  assign hit    = (paddr == 2'(REG_HOLD_TICKS * 4));
  assign pready = 1'b1;

  // Register write
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_ticks <= TIME_W'(HOLD_RESET);
    end else if (psel && penable && pwrite && hit) begin
      hold_ticks <= pwdata;
    end
  end

  // Read back
  assign prdata = hit ? hold_ticks : 32'd0;

endmodule

// ----- src/ipr_store.sv -----
// Entry store: link, state and expiry memories with one shared read address.
// Depends on ipr_pkg; driven by the sequencer in ipr_seq.
module ipr_store import ipr_pkg::*; (
  input  logic       clk,
  input  store_req_t req,
  output store_rsp_t rsp
);

  logic [LINK_W-1:0] next_link   [NUM_IDS];
  entry_state_t      entry_state [NUM_IDS];
  logic [TIME_W-1:0] expiry      [NUM_IDS];

  // Link memory
  always_ff @(posedge clk) begin
    if (req.link_we) begin
      next_link[req.wr_addr] <= req.link_wd;
    end
    rsp.link <= next_link[req.rd_addr];
  end

  // State memory
  always_ff @(posedge clk) begin
    if (req.state_we) begin
      entry_state[req.wr_addr] <= req.state_wd;
    end
    rsp.state <= entry_state[req.rd_addr];
  end

  // Expiry memory, never cleared
  always_ff @(posedge clk) begin
    if (req.exp_we) begin
      expiry[req.wr_addr] <= req.exp_wd;
    end
    rsp.expiry <= expiry[req.rd_addr];
  end

endmodule

// ----- src/ipr_seq.sv -----
// Request sequencer: list heads, counters and the single compare/add unit.
// Depends on ipr_pkg; works the entry store in ipr_store.
module ipr_seq import ipr_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  logic [1:0]          req_type,
  input  logic [REQ_ID_W-1:0] id,
  input  logic [TIME_W-1:0]   now,
  input  logic [TIME_W-1:0]   hold_ticks,
  output logic                done,
  output logic [9:0]          alloc_id,
  output logic [1:0]          status,
  output logic [CNT_W-1:0]    used_count,
  output logic [CNT_W-1:0]    held_count,
  output store_req_t          sreq,
  input  store_rsp_t          srsp
);

  typedef enum logic [10:0] {
    S_IDLE     = 11'b000_0000_0001,
    S_CLR      = 11'b000_0000_0010,
    S_A_RD     = 11'b000_0000_0100,
    S_A_CHK    = 11'b000_0000_1000,
    S_A_POP_RD = 11'b000_0001_0000,
    S_A_POP    = 11'b000_0010_0000,
    S_F_RD     = 11'b000_0100_0000,
    S_F_CHK    = 11'b000_1000_0000,
    S_F_LINK   = 11'b001_0000_0000,
    S_R_RD     = 11'b010_0000_0000,
    S_R_REL    = 11'b100_0000_0000
  } state_t;

  state_t              state, state_next;
  logic [LINK_W-1:0]   free_head, free_head_next;
  logic [LINK_W-1:0]   q_head, q_head_next;
  logic [LINK_W-1:0]   q_tail, q_tail_next;
  logic [CNT_W-1:0]    used_count_next, held_count_next;
  logic [ID_W-1:0]     clr_cnt, clr_cnt_next;
  logic                report, report_next;
  logic                done_next;
  logic [9:0]          alloc_id_next;
  status_t             status_q, status_next;
  logic [REQ_ID_W-1:0] id_q;
  logic [TIME_W-1:0]   now_q;
  logic [TIME_W:0]     stamp_sum;
  logic [TIME_W-1:0]   stamp;
  logic                id_in_range;
  logic [ID_W-1:0]     id_idx;

  assign busy   = (state != S_IDLE);
  assign status = status_q;

  // Shared arithmetic: saturating expiry stamp
  assign stamp_sum = {1'b0, now_q} + {1'b0, hold_ticks};
  assign stamp     = stamp_sum[TIME_W] ? {TIME_W{1'b1}} : stamp_sum[TIME_W-1:0];

  assign id_in_range = (32'(id_q) < NUM_IDS);
  assign id_idx      = ID_W'(id_q);

  // Latch the request item
  always_ff @(posedge clk) begin
    if (start && !busy) begin
      id_q  <= id;
      now_q <= now;
    end
  end

  // Next state and datapath
  always_comb begin
    state_next      = state;
    free_head_next  = free_head;
    q_head_next     = q_head;
    q_tail_next     = q_tail;
    used_count_next = used_count;
    held_count_next = held_count;
    clr_cnt_next    = clr_cnt;
    report_next     = report;
    done_next       = 1'b0;
    alloc_id_next   = alloc_id;
    status_next     = status_q;
    sreq            = '0;

    case (state)
      S_IDLE: begin
        if (start) begin
          alloc_id_next = '0;
          status_next   = STAT_OK;
          case (req_t'(req_type))
            REQ_ALLOC:   state_next = S_A_RD;
            REQ_FREE:    state_next = S_F_RD;
            REQ_RELEASE: state_next = S_R_RD;
            default: begin
              state_next   = S_CLR;
              clr_cnt_next = '0;
              report_next  = 1'b1;
            end
          endcase
        end
      end

      // Sweep: relink every entry to its successor and mark it free
      S_CLR: begin
        sreq.wr_addr    = clr_cnt;
        sreq.link_we    = 1'b1;
        sreq.link_wd    = LINK_W'(clr_cnt) + LINK_W'(1);
        sreq.state_we   = 1'b1;
        sreq.state_wd   = ES_FREE;
        free_head_next  = '0;
        q_head_next     = LINK_NULL;
        q_tail_next     = LINK_NULL;
        used_count_next = '0;
        held_count_next = '0;
        clr_cnt_next    = clr_cnt + ID_W'(1);
        if (clr_cnt == ID_W'(NUM_IDS - 1)) begin
          state_next = S_IDLE;
          done_next  = report;
        end
      end

      // Allocate: look at the oldest quarantined entry
      S_A_RD: begin
        sreq.rd_addr = ID_W'(q_head);
        state_next   = is_null(q_head) ? S_A_POP_RD : S_A_CHK;
      end

      S_A_CHK, S_R_REL: begin
        if (state == S_R_REL || srsp.expiry < now_q) begin
          // Move quarantine head to the free list head
          sreq.wr_addr   = ID_W'(q_head);
          sreq.link_we   = 1'b1;
          sreq.link_wd   = free_head;
          sreq.state_we  = 1'b1;
          sreq.state_wd  = ES_FREE;
          free_head_next = q_head;
          q_head_next    = srsp.link;
          if (is_null(srsp.link)) begin
            q_head_next = LINK_NULL;
            q_tail_next = LINK_NULL;
          end
          if (used_count != '0) begin
            used_count_next = used_count - CNT_W'(1);
          end
          state_next = (state == S_R_REL) ? S_R_RD : S_A_RD;
        end else begin
          state_next = S_A_POP_RD;
        end
      end

      S_A_POP_RD: begin
        sreq.rd_addr = ID_W'(free_head);
        if (is_null(free_head)) begin
          status_next = STAT_EMPTY;
          done_next   = 1'b1;
          state_next  = S_IDLE;
        end else begin
          state_next = S_A_POP;
        end
      end

      // Pop the free list head
      S_A_POP: begin
        sreq.wr_addr    = ID_W'(free_head);
        sreq.state_we   = 1'b1;
        sreq.state_wd   = ES_ALLOC;
        free_head_next  = srsp.link;
        used_count_next = used_count + CNT_W'(1);
        held_count_next = held_count + CNT_W'(1);
        alloc_id_next   = 10'(free_head);
        done_next       = 1'b1;
        state_next      = S_IDLE;
      end

      // Free: screen the id, then read its state
      S_F_RD: begin
        sreq.rd_addr = id_idx;
        if (id_q[REQ_ID_W-1]) begin
          status_next = STAT_IGNORED;
          done_next   = 1'b1;
          state_next  = S_IDLE;
        end else if (!id_in_range) begin
          status_next = STAT_BAD;
          done_next   = 1'b1;
          state_next  = S_IDLE;
        end else begin
          state_next = S_F_CHK;
        end
      end

      S_F_CHK: begin
        if (srsp.state != ES_ALLOC) begin
          status_next = STAT_BAD;
          done_next   = 1'b1;
          state_next  = S_IDLE;
        end else begin
          sreq.wr_addr  = id_idx;
          sreq.state_we = 1'b1;
          sreq.state_wd = ES_HELD;
          sreq.exp_we   = 1'b1;
          sreq.exp_wd   = stamp;
          sreq.link_we  = 1'b1;
          sreq.link_wd  = LINK_NULL;
          if (held_count != '0) begin
            held_count_next = held_count - CNT_W'(1);
          end
          if (is_null(q_tail)) begin
            q_head_next = LINK_W'(id_idx);
            q_tail_next = LINK_W'(id_idx);
            done_next   = 1'b1;
            state_next  = S_IDLE;
          end else begin
            state_next = S_F_LINK;
          end
        end
      end

      // Append to the quarantine tail
      S_F_LINK: begin
        sreq.wr_addr = ID_W'(q_tail);
        sreq.link_we = 1'b1;
        sreq.link_wd = LINK_W'(id_idx);
        q_tail_next  = LINK_W'(id_idx);
        done_next    = 1'b1;
        state_next   = S_IDLE;
      end

      // Release all: walk the quarantine list
      S_R_RD: begin
        sreq.rd_addr = ID_W'(q_head);
        if (is_null(q_head)) begin
          done_next  = 1'b1;
          state_next = S_IDLE;
        end else begin
          state_next = S_R_REL;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Control state; reset starts a silent clearing sweep
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLR;
      clr_cnt    <= '0;
      report     <= 1'b0;
      done       <= 1'b0;
      free_head  <= '0;
      q_head     <= LINK_NULL;
      q_tail     <= LINK_NULL;
      used_count <= '0;
      held_count <= '0;
    end else begin
      state      <= state_next;
      clr_cnt    <= clr_cnt_next;
      report     <= report_next;
      done       <= done_next;
      free_head  <= free_head_next;
      q_head     <= q_head_next;
      q_tail     <= q_tail_next;
      used_count <= used_count_next;
      held_count <= held_count_next;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    alloc_id <= alloc_id_next;
    status_q <= status_next;
  end

endmodule

// ----- src/id_pool_with_reuse_delay.sv -----
// Top level of the id pool with reuse delay.
// Depends on ipr_pkg, ipr_cfg, ipr_store and ipr_seq.

// Hands out ids from a last-in-first-out free list; freed ids wait in a
// first-in-first-out quarantine until their stamp (now + hold_ticks, saturating)
// is earlier than the now of an allocate, or until a release-all. Start a
// request with start while busy is low; one result follows on the done strobe,
// valid for that single cycle, and must be taken then. One sequencer drives an
// entry store with one read port, one write port and a registered read, so each
// list step reads an entry and then decides on it: allocate returns expired ids
// from the quarantine head to the free list, then pops the free list head; free
// screens the id, reads its state and appends it to the quarantine tail;
// release-all walks the quarantine list; clear sweeps all NUM_IDS (1024) entries.
// After reset the same clearing sweep runs with busy high and gives no result.
// hold_ticks sits at byte address 0 of the register port; write it while idle.
module id_pool_with_reuse_delay import ipr_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  output logic                   busy,
  input  logic [1:0]             req_type,
  input  logic signed [REQ_ID_W-1:0] id,
  input  logic [TIME_W-1:0]      now,
  output logic                   done,
  output logic [9:0]             alloc_id,
  output logic [1:0]             status,
  output logic [OUT_CNT_W-1:0]   usage,
  output logic [OUT_CNT_W-1:0]   in_usage,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [1:0]             paddr,
  input  logic [31:0]            pwdata,
  output logic [31:0]            prdata,
  output logic                   pready
);

  logic [TIME_W-1:0] hold_ticks;
  logic [CNT_W-1:0]  used_count;
  logic [CNT_W-1:0]  held_count;
  store_req_t        sreq;
  store_rsp_t        srsp;

  // Register port
  ipr_cfg u_cfg (
    .clk        (clk),
    .rst        (rst),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .hold_ticks (hold_ticks)
  );

  // Sequencer
  ipr_seq u_seq (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .req_type   (req_type),
    .id         (id),
    .now        (now),
    .hold_ticks (hold_ticks),
    .done       (done),
    .alloc_id   (alloc_id),
    .status     (status),
    .used_count (used_count),
    .held_count (held_count),
    .sreq       (sreq),
    .srsp       (srsp)
  );

  // Entry store
  ipr_store u_store (
    .clk (clk),
    .req (sreq),
    .rsp (srsp)
  );

  // Counts as seen on the result
  assign usage    = OUT_CNT_W'(used_count);
  assign in_usage = OUT_CNT_W'(held_count);

  // Checks
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result strobe while sequencer busy");

  a_reset_sweep: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> busy)
    else $error("clearing sweep not running after reset");

  a_counts: assert property (@(posedge clk) disable iff (rst)
    done |-> (held_count <= used_count))
    else $error("allocated count above usage count");

  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    (done && (status == STAT_EMPTY)) |-> (alloc_id == 10'd0))
    else $error("empty pool result carries an id");

endmodule
